>>> rtl/bx3_pkg.sv
// Shared constants and register indexes for the 3x3 box-sum extrema finder.
package bx3_pkg;

	// Default geometry and pixel width.
	localparam int MAX_DIM_DEF    = 32;
	localparam int PIXEL_BITS_DEF = 8;

	// Window shape; a grid is never smaller than one window.
	localparam int WIN     = 3;
	localparam int MIN_DIM = 3;

	// Configuration port.
	localparam int CFG_W     = 6;
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_GRID_ROWS = 1'b0;
	localparam cfg_idx_t REG_GRID_COLS = 1'b1;
	localparam logic [CFG_W-1:0] DIM_RESET = 6'd3;

	// Result field widths.
	localparam int VAL_W  = 8;
	localparam int SUM_W  = 12;
	localparam int POS_W  = 5;
	localparam int LINE_W = 2;

	// Result sequencing: three max rows, then three min rows.
	localparam int RES_IDX_W = 3;
	typedef logic [RES_IDX_W-1:0] res_idx_t;
	localparam res_idx_t RES_FIRST_LOW = 3'd3;
	localparam res_idx_t RES_LAST      = 3'd5;

endpackage

>>> rtl/bx3_line_store.sv
// Line store: one synchronous memory holding the two previous rows per column.
module bx3_line_store #(
	parameter int DEPTH = bx3_pkg::MAX_DIM_DEF,
	parameter int WIDTH = 2 * bx3_pkg::PIXEL_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/box3x3_sum_extrema_finder.sv
// Top level: streaming 3x3 box-sum arg-max / arg-min over a raster grid.
//
// Usage:
//   Write grid_rows (index REG_GRID_ROWS) and grid_cols (index REG_GRID_COLS)
//   on the cfg_write port while the block is idle; values are clamped to
//   3..MAX_DIM when used. Both reset to 3.
//   Stream pixels in raster order on pixel_valid/pixel_ready. One transaction
//   per cycle is sustained while pixel_ready is high: the line store is read
//   when a pixel is taken and written back in the next cycle, and the window
//   sum and the extrema compare each take one pipeline stage.
//   After the last pixel of a grid six result transactions come out on
//   result_valid/result_ready: rows 0..2 of the max-sum window, then rows
//   0..2 of the min-sum window, last set on the sixth. result_valid rises
//   once the last pixel has passed the pipeline into the result buffer; the six
//   results then leave at one per cycle while result_ready is high.
//   Results wait in their own buffer, so the next grid streams in while they
//   drain. Only the last pixel of the next grid is held off (pixel_ready low)
//   until the receiver has taken all six results of the previous grid.
//   Reset clears the counters, pipeline and result buffer; the line store
//   content is not cleared; its stale entries reach only unscored windows.
//   Ties keep the earliest window in raster order.
module box3x3_sum_extrema_finder #(
	parameter int MAX_DIM    = bx3_pkg::MAX_DIM_DEF,
	parameter int PIXEL_BITS = bx3_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                cfg_write,
	input  logic [bx3_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bx3_pkg::CFG_W-1:0]           cfg_data,
	// pixel stream
	input  logic                                pixel_valid,
	output logic                                pixel_ready,
	input  logic [bx3_pkg::VAL_W-1:0]           pixel,
	// result stream
	output logic                                result_valid,
	input  logic                                result_ready,
	output logic                                which_extreme,
	output logic [bx3_pkg::LINE_W-1:0]          window_line,
	output logic [bx3_pkg::VAL_W-1:0]           value_left,
	output logic [bx3_pkg::VAL_W-1:0]           value_mid,
	output logic [bx3_pkg::VAL_W-1:0]           value_right,
	output logic [bx3_pkg::SUM_W-1:0]           box_sum,
	output logic [bx3_pkg::POS_W-1:0]           top_row,
	output logic [bx3_pkg::POS_W-1:0]           left_col,
	output logic                                last
);

	localparam int AW  = $clog2(MAX_DIM);                       // counter / address bits
	localparam int DW  = ($clog2(MAX_DIM + 1) > bx3_pkg::CFG_W) ?
	                     $clog2(MAX_DIM + 1) : bx3_pkg::CFG_W;  // dimension compare bits
	localparam int PB  = PIXEL_BITS;
	localparam int CSW = PIXEL_BITS + 2;                        // one column of three
	localparam int SW  = PIXEL_BITS + 4;                        // nine pixels

	typedef logic [bx3_pkg::WIN-1:0][bx3_pkg::WIN-1:0][PB-1:0] win_t;

	// ---------------- configuration ----------------
	logic [bx3_pkg::CFG_W-1:0] grid_rows_q, grid_cols_q;
	logic [DW-1:0]             rows_raw, cols_raw, rows_dim, cols_dim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_rows_q <= bx3_pkg::DIM_RESET;
			grid_cols_q <= bx3_pkg::DIM_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				bx3_pkg::REG_GRID_ROWS: grid_rows_q <= cfg_data;
				bx3_pkg::REG_GRID_COLS: grid_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign rows_raw = DW'(grid_rows_q);
	assign cols_raw = DW'(grid_cols_q);

	always_comb begin
		if (rows_raw < DW'(bx3_pkg::MIN_DIM))  rows_dim = DW'(bx3_pkg::MIN_DIM);
		else if (rows_raw > DW'(MAX_DIM))      rows_dim = DW'(MAX_DIM);
		else                                   rows_dim = rows_raw;
		if (cols_raw < DW'(bx3_pkg::MIN_DIM))  cols_dim = DW'(bx3_pkg::MIN_DIM);
		else if (cols_raw > DW'(MAX_DIM))      cols_dim = DW'(MAX_DIM);
		else                                   cols_dim = cols_raw;
	end

	// ---------------- input stage: raster counters ----------------
	logic [AW-1:0] row_q, col_q;
	logic          row_end, grid_end, pix_acc;
	logic          busy_q;   // result buffer holds undelivered results

	assign row_end  = (DW'(col_q) + DW'(1)) >= cols_dim;
	assign grid_end = row_end && ((DW'(row_q) + DW'(1)) >= rows_dim);

	// The grid's last pixel would load the result buffer; hold it while full.
	assign pixel_ready = !(busy_q && grid_end);
	assign pix_acc     = pixel_valid && pixel_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (pix_acc) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= grid_end ? '0 : row_q + AW'(1);
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	// ---------------- stage 1: line store data returns ----------------
	logic            v_s1, gend_s1;
	logic [PB-1:0]   px_s1;
	logic [AW-1:0]   row_s1, col_s1;
	logic [2*PB-1:0] ls_rd_data;
	logic [PB-1:0]   ls_two, ls_above;

	bx3_line_store #(
		.DEPTH(MAX_DIM),
		.WIDTH(2 * PB)
	) u_line_store (
		.clk    (clk),
		.rd_en  (pix_acc),
		.rd_addr(col_q),
		.rd_data(ls_rd_data),
		.wr_en  (v_s1),
		.wr_addr(col_s1),
		.wr_data({ls_above, px_s1})   // above row moves to two-above
	);

	assign ls_two   = ls_rd_data[2*PB-1:PB];
	assign ls_above = ls_rd_data[PB-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else         v_s1 <= pix_acc;
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			px_s1   <= PB'(pixel);
			row_s1  <= row_q;
			col_s1  <= col_q;
			gend_s1 <= grid_end;
		end
	end

	// Window shift and running column sums.
	win_t           win_q;
	logic [CSW-1:0] cs_mid_q, cs_right_q, cs_new;
	logic [SW-1:0]  sum_new;

	assign cs_new  = CSW'(ls_two) + CSW'(ls_above) + CSW'(px_s1);
	assign sum_new = SW'(cs_mid_q) + SW'(cs_right_q) + SW'(cs_new);

	logic          v_s2, full_s2, gend_s2;
	logic [SW-1:0] sum_s2;
	logic [AW-1:0] prow_s2, pcol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else         v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int k = 0; k < bx3_pkg::WIN; k++) begin
				win_q[k][0] <= win_q[k][1];
				win_q[k][1] <= win_q[k][2];
			end
			win_q[0][2] <= ls_two;
			win_q[1][2] <= ls_above;
			win_q[2][2] <= px_s1;
			cs_mid_q    <= cs_right_q;
			cs_right_q  <= cs_new;
			sum_s2      <= sum_new;
			full_s2     <= (row_s1 >= AW'(bx3_pkg::WIN - 1)) &&
			               (col_s1 >= AW'(bx3_pkg::WIN - 1));
			prow_s2     <= row_s1 - AW'(bx3_pkg::WIN - 1);
			pcol_s2     <= col_s1 - AW'(bx3_pkg::WIN - 1);
			gend_s2     <= gend_s1;
		end
	end

	// ---------------- stage 2: extrema update ----------------
	logic          have_first_q;
	logic [SW-1:0] hi_sum_q, lo_sum_q;
	logic [AW-1:0] hi_row_q, hi_col_q, lo_row_q, lo_col_q;
	win_t          hi_pix_q, lo_pix_q;
	logic          hi_take, lo_take, snap;

	// Strict compares: ties keep the earlier window.
	assign hi_take = v_s2 && full_s2 && (!have_first_q || (sum_s2 > hi_sum_q));
	assign lo_take = v_s2 && full_s2 && (!have_first_q || (sum_s2 < lo_sum_q));
	assign snap    = v_s2 && gend_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_first_q <= 1'b0;
		end else if (snap) begin
			have_first_q <= 1'b0;
		end else if (v_s2 && full_s2) begin
			have_first_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hi_take) begin
			hi_sum_q <= sum_s2;
			hi_row_q <= prow_s2;
			hi_col_q <= pcol_s2;
			hi_pix_q <= win_q;
		end
		if (lo_take) begin
			lo_sum_q <= sum_s2;
			lo_row_q <= prow_s2;
			lo_col_q <= pcol_s2;
			lo_pix_q <= win_q;
		end
	end

	// ---------------- result buffer ----------------
	logic [SW-1:0]     ob_hi_sum_q, ob_lo_sum_q;
	logic [AW-1:0]     ob_hi_row_q, ob_hi_col_q, ob_lo_row_q, ob_lo_col_q;
	win_t              ob_hi_pix_q, ob_lo_pix_q;
	bx3_pkg::res_idx_t idx_q;
	logic              res_acc, sel_lo;
	logic [1:0]        line_sel;

	assign res_acc = result_valid && result_ready;

	// Snapshot includes an update made by the grid's final window.
	always_ff @(posedge clk) begin
		if (snap) begin
			ob_hi_sum_q <= hi_take ? sum_s2  : hi_sum_q;
			ob_hi_row_q <= hi_take ? prow_s2 : hi_row_q;
			ob_hi_col_q <= hi_take ? pcol_s2 : hi_col_q;
			ob_hi_pix_q <= hi_take ? win_q   : hi_pix_q;
			ob_lo_sum_q <= lo_take ? sum_s2  : lo_sum_q;
			ob_lo_row_q <= lo_take ? prow_s2 : lo_row_q;
			ob_lo_col_q <= lo_take ? pcol_s2 : lo_col_q;
			ob_lo_pix_q <= lo_take ? win_q   : lo_pix_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (snap) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (res_acc) begin
			if (idx_q == bx3_pkg::RES_LAST) begin
				busy_q <= 1'b0;
				idx_q  <= '0;
			end else begin
				idx_q <= idx_q + bx3_pkg::RES_IDX_W'(1);
			end
		end
	end

	assign sel_lo   = idx_q >= bx3_pkg::RES_FIRST_LOW;
	assign line_sel = sel_lo ? 2'(idx_q - bx3_pkg::RES_FIRST_LOW) : 2'(idx_q);

	assign result_valid  = busy_q;
	assign which_extreme = sel_lo;
	assign window_line   = line_sel;
	assign last          = (idx_q == bx3_pkg::RES_LAST);
	assign value_left    = bx3_pkg::VAL_W'(sel_lo ? ob_lo_pix_q[line_sel][0]
	                                              : ob_hi_pix_q[line_sel][0]);
	assign value_mid     = bx3_pkg::VAL_W'(sel_lo ? ob_lo_pix_q[line_sel][1]
	                                              : ob_hi_pix_q[line_sel][1]);
	assign value_right   = bx3_pkg::VAL_W'(sel_lo ? ob_lo_pix_q[line_sel][2]
	                                              : ob_hi_pix_q[line_sel][2]);
	assign box_sum       = bx3_pkg::SUM_W'(sel_lo ? ob_lo_sum_q : ob_hi_sum_q);
	assign top_row       = bx3_pkg::POS_W'(sel_lo ? ob_lo_row_q : ob_hi_row_q);
	assign left_col      = bx3_pkg::POS_W'(sel_lo ? ob_lo_col_q : ob_hi_col_q);

	// ---------------- assertions ----------------
	// Read and write-back of the line store never hit the same column at once.
	a_ls_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && v_s1) |-> (col_q != col_s1))
		else $error("line store read and write to the same column");

	// A grid snapshot never overwrites undelivered results.
	a_snap_free: assert property (@(posedge clk) disable iff (!arst_n)
		snap |-> !busy_q)
		else $error("result buffer overwritten");

	// Taking the sixth result empties the buffer unless a new grid loads it.
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(res_acc && last && !snap) |=> !result_valid)
		else $error("result buffer not released after last transaction");

	// Once a window is recorded, the min record never exceeds the max record.
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		have_first_q |-> (lo_sum_q <= hi_sum_q))
		else $error("min sum above max sum");

endmodule

>>> verif/tb_top.sv
// Testbench for the 3x3 box-sum extrema finder: scoreboard class, drivers and stimulus.
`timescale 1ns / 100ps

module tb_top;

	// Cycles to let pass after the last expected row before touching the registers,
	// as margin for the pipe.
	localparam int DRAIN_PAUSE = 8;
	// Long receiver hold-off used to back the block up into its pixel input.
	localparam int HOLD_OFF_CYCLES = 400;

	// One result transaction as seen on the result port.
	typedef struct packed {
		logic                        which_extreme;
		logic [bx3_pkg::LINE_W-1:0]  window_line;
		logic [bx3_pkg::VAL_W-1:0]   value_left;
		logic [bx3_pkg::VAL_W-1:0]   value_mid;
		logic [bx3_pkg::VAL_W-1:0]   value_right;
		logic [bx3_pkg::SUM_W-1:0]   box_sum;
		logic [bx3_pkg::POS_W-1:0]   top_row;
		logic [bx3_pkg::POS_W-1:0]   left_col;
		logic                        last;
	} window_row_t;

	// How the pixels of one grid are chosen.
	typedef enum {
		FILL_RANDOM,
		FILL_EXTREME,  // each pixel 0 or 255
		FILL_FULL,     // all 255: largest possible box sum
		FILL_ZERO,     // all 0
		FILL_FLAT,     // one constant: every window ties
		FILL_RISE,     // brightens toward bottom-right
		FILL_FALL      // darkens toward bottom-right
	} grid_fill_t;

	// Scoreboard: mirrors the window scan and holds the rows still to come.
	class extrema_scoreboard;
		logic [bx3_pkg::CFG_W-1:0]  rows_reg, cols_reg;
		logic [bx3_pkg::VAL_W-1:0]  line_above [bx3_pkg::MAX_DIM_DEF];
		logic [bx3_pkg::VAL_W-1:0]  line_two_above [bx3_pkg::MAX_DIM_DEF];
		logic [bx3_pkg::VAL_W-1:0]  win [9];
		int unsigned                row_cnt, col_cnt;
		bit                         have_first;
		logic [bx3_pkg::SUM_W-1:0]  hi_sum, lo_sum;
		logic [bx3_pkg::POS_W-1:0]  hi_top, hi_left, lo_top, lo_left;
		logic [bx3_pkg::VAL_W-1:0]  hi_px [9];
		logic [bx3_pkg::VAL_W-1:0]  lo_px [9];
		window_row_t                rows_due [$];
		int                         errors;

		function new();
			errors = 0;
		endfunction

		function void reset_state();
			rows_reg = bx3_pkg::DIM_RESET;
			cols_reg = bx3_pkg::DIM_RESET;
			for (int i = 0; i < bx3_pkg::MAX_DIM_DEF; i++) begin
				line_above[i] = '0;
				line_two_above[i] = '0;
			end
			for (int i = 0; i < 9; i++) begin
				win[i] = '0;
				hi_px[i] = '0;
				lo_px[i] = '0;
			end
			row_cnt = 0;
			col_cnt = 0;
			have_first = 1'b0;
			hi_sum = '0;
			lo_sum = '0;
			hi_top = '0;
			hi_left = '0;
			lo_top = '0;
			lo_left = '0;
			rows_due.delete();
		endfunction

		function void write_reg(bx3_pkg::cfg_idx_t idx, logic [bx3_pkg::CFG_W-1:0] data);
			if (idx == bx3_pkg::REG_GRID_ROWS)
				rows_reg = data;
			else
				cols_reg = data;
		endfunction

		// Out-of-range dimensions saturate to 3..MAX_DIM.
		function int dim_used(logic [bx3_pkg::CFG_W-1:0] v);
			if (v < bx3_pkg::MIN_DIM)
				return bx3_pkg::MIN_DIM;
			if (v > bx3_pkg::MAX_DIM_DEF)
				return bx3_pkg::MAX_DIM_DEF;
			return int'(v);
		endfunction

		function void push_window(logic which, logic [bx3_pkg::VAL_W-1:0] px [9],
				logic [bx3_pkg::SUM_W-1:0] sum, logic [bx3_pkg::POS_W-1:0] top,
				logic [bx3_pkg::POS_W-1:0] left, bit ends_grid);
			window_row_t row;
			for (int k = 0; k < bx3_pkg::WIN; k++) begin
				row.which_extreme = which;
				row.window_line   = bx3_pkg::LINE_W'(k);
				row.value_left    = px[k*3];
				row.value_mid     = px[k*3+1];
				row.value_right   = px[k*3+2];
				row.box_sum       = sum;
				row.top_row       = top;
				row.left_col      = left;
				row.last          = ends_grid && (k == bx3_pkg::WIN - 1);
				rows_due.push_back(row);
			end
		endfunction

		function void note_pixel(logic [bx3_pkg::VAL_W-1:0] px);
			int nr, nc, r, c, ci, sum;
			logic [bx3_pkg::VAL_W-1:0] col_in [3];
			nr = dim_used(rows_reg);
			nc = dim_used(cols_reg);
			r = row_cnt;
			c = col_cnt;
			ci = c % bx3_pkg::MAX_DIM_DEF;
			col_in[0] = line_two_above[ci];
			col_in[1] = line_above[ci];
			col_in[2] = px;
			for (int k = 0; k < 3; k++) begin
				win[k*3]   = win[k*3+1];
				win[k*3+1] = win[k*3+2];
				win[k*3+2] = col_in[k];
			end
			line_two_above[ci] = line_above[ci];
			line_above[ci] = px;

			if (r >= 2 && c >= 2) begin
				sum = 0;
				for (int k = 0; k < 9; k++)
					sum += win[k];
				if (!have_first || sum > hi_sum) begin
					hi_sum = bx3_pkg::SUM_W'(sum);
					hi_top = bx3_pkg::POS_W'(r - 2);
					hi_left = bx3_pkg::POS_W'(c - 2);
					hi_px = win;
				end
				if (!have_first || sum < lo_sum) begin
					lo_sum = bx3_pkg::SUM_W'(sum);
					lo_top = bx3_pkg::POS_W'(r - 2);
					lo_left = bx3_pkg::POS_W'(c - 2);
					lo_px = win;
				end
				have_first = 1'b1;
			end

			if (c + 1 < nc) begin
				col_cnt = c + 1;
				return;
			end
			col_cnt = 0;
			if (r + 1 < nr) begin
				row_cnt = r + 1;
				return;
			end
			row_cnt = 0;
			push_window(1'b0, hi_px, hi_sum, hi_top, hi_left, 1'b0);
			push_window(1'b1, lo_px, lo_sum, lo_top, lo_left, 1'b1);
			have_first = 1'b0;
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_row(window_row_t got);
			window_row_t want;
			if (rows_due.size() == 0) begin
				errors++;
				$display("%0t: result with none expected, expected nothing, got line %0d sum %0d",
					$time, got.window_line, got.box_sum);
				return;
			end
			want = rows_due.pop_front();
			compare_field("which_extreme", want.which_extreme, got.which_extreme);
			compare_field("window_line", want.window_line, got.window_line);
			compare_field("value_left", want.value_left, got.value_left);
			compare_field("value_mid", want.value_mid, got.value_mid);
			compare_field("value_right", want.value_right, got.value_right);
			compare_field("box_sum", want.box_sum, got.box_sum);
			compare_field("top_row", want.top_row, got.top_row);
			compare_field("left_col", want.left_col, got.left_col);
			compare_field("last", want.last, got.last);
		endfunction
	endclass

	// DUT connections; every input has a known value from time zero.
	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        cfg_write = 1'b0;
	bx3_pkg::cfg_idx_t           cfg_index = bx3_pkg::REG_GRID_ROWS;
	logic [bx3_pkg::CFG_W-1:0]   cfg_data = '0;
	logic                        pixel_valid = 1'b0;
	logic                        pixel_ready;
	logic [bx3_pkg::VAL_W-1:0]   pixel = '0;
	logic                        result_valid;
	logic                        result_ready = 1'b0;
	logic                        which_extreme;
	logic [bx3_pkg::LINE_W-1:0]  window_line;
	logic [bx3_pkg::VAL_W-1:0]   value_left, value_mid, value_right;
	logic [bx3_pkg::SUM_W-1:0]   box_sum;
	logic [bx3_pkg::POS_W-1:0]   top_row, left_col;
	logic                        last;

	// Idling knobs, in percent of cycles, and the receiver hold-off counter.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int recv_hold = 0;

	extrema_scoreboard sb = new();

	box3x3_sum_extrema_finder u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.pixel_valid   (pixel_valid),
		.pixel_ready   (pixel_ready),
		.pixel         (pixel),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.which_extreme (which_extreme),
		.window_line   (window_line),
		.value_left    (value_left),
		.value_mid     (value_mid),
		.value_right   (value_right),
		.box_sum       (box_sum),
		.top_row       (top_row),
		.left_col      (left_col),
		.last          (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: checks each accepted result transaction, then picks ready for the
	// next cycle. Signals are sampled at the edge, before any update it causes.
	initial begin
		window_row_t got;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && result_ready) begin
				got.which_extreme = which_extreme;
				got.window_line   = window_line;
				got.value_left    = value_left;
				got.value_mid     = value_mid;
				got.value_right   = value_right;
				got.box_sum       = box_sum;
				got.top_row       = top_row;
				got.left_col      = left_col;
				got.last          = last;
				sb.check_row(got);
			end
			if (recv_hold > 0) begin
				// long hold-off: results pile up and the block stalls the pixel side
				recv_hold--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Hard limit on the run; far beyond the slowest correct run.
	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	task automatic set_idle(int send_pct, int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
	endtask

	// Write both dimensions; only called while the block is idle.
	task automatic write_regs(logic [bx3_pkg::CFG_W-1:0] rows_val,
			logic [bx3_pkg::CFG_W-1:0] cols_val);
		cfg_write <= 1'b1;
		cfg_index <= bx3_pkg::REG_GRID_ROWS;
		cfg_data <= rows_val;
		@(posedge clk);
		sb.write_reg(bx3_pkg::REG_GRID_ROWS, rows_val);
		cfg_index <= bx3_pkg::REG_GRID_COLS;
		cfg_data <= cols_val;
		@(posedge clk);
		sb.write_reg(bx3_pkg::REG_GRID_COLS, cols_val);
		cfg_write <= 1'b0;
	endtask

	// Offer one pixel and hold it until the transaction completes. Valid is only
	// dropped at the start of a gap, so it never toggles twice in one step.
	task automatic send_pixel(logic [bx3_pkg::VAL_W-1:0] px);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			pixel_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		pixel <= px;
		pixel_valid <= 1'b1;
		do
			@(posedge clk);
		while (!pixel_ready);
		sb.note_pixel(px);
	endtask

	// One whole grid at the current register setting, raster order.
	task automatic send_grid(grid_fill_t fill);
		int nr, nc, level;
		logic [bx3_pkg::VAL_W-1:0] px;
		nr = sb.dim_used(sb.rows_reg);
		nc = sb.dim_used(sb.cols_reg);
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				level = (r + c) * 4 + $urandom_range(3);
				if (level > 255)
					level = 255;
				case (fill)
					FILL_RANDOM:  px = bx3_pkg::VAL_W'($urandom_range(255));
					FILL_EXTREME: px = $urandom_range(1) ? 8'hFF : 8'h00;
					FILL_FULL:    px = 8'hFF;
					FILL_ZERO:    px = 8'h00;
					FILL_FLAT:    px = 8'h5A;
					FILL_RISE:    px = bx3_pkg::VAL_W'(level);
					default: begin
						px = bx3_pkg::VAL_W'(255 - level);
					end
				endcase
				send_pixel(px);
			end
		end
	endtask

	// Wait until every expected row has come back, then let the pipe settle.
	task automatic drain();
		pixel_valid <= 1'b0;
		while (sb.rows_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE) @(posedge clk);
	endtask

	initial begin
		sb.reset_state();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset geometry (3x3), largest and smallest sums, then
		// dimensions below range (clamped to 3) with all windows tied.
		send_grid(FILL_FULL);
		send_grid(FILL_ZERO);
		drain();
		write_regs(6'd0, 6'd1);
		send_grid(FILL_FLAT);
		drain();

		// Tallest grid (63 saturates to 32), columns below range; winner near the bottom.
		set_idle(0, 0);
		write_regs(6'd63, 6'd2);
		send_grid(FILL_RISE);
		drain();

		// Widest grid, sparse sender.
		set_idle(83, 0);
		write_regs(6'd3, 6'd32);
		send_grid(FILL_FALL);
		drain();

		// Slow receiver.
		set_idle(0, 83);
		write_regs(6'd4, 6'd5);
		send_grid(FILL_RANDOM);
		drain();

		// Light idling on both sides.
		set_idle(16, 16);
		write_regs(6'd5, 6'd3);
		send_grid(FILL_RANDOM);
		send_grid(FILL_EXTREME);
		drain();

		// Back-pressure: receiver holds off while grids keep streaming in, so the
		// result buffer fills and the next grid's last pixel is held.
		set_idle(0, 0);
		write_regs(6'd3, 6'd3);
		recv_hold = HOLD_OFF_CYCLES;
		for (int g = 0; g < 2; g++)
			send_grid(FILL_RANDOM);
		drain();

		if (sb.rows_due.size() != 0)
			sb.errors++;
		if (sb.errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
